/* rtl/core/sorted_priority_queue_unit_defines.svh */
// Assertion macros for the sorted priority queue unit.
// Used by the top level; the clock i_clk and reset i_rst_n must be in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sorted priority queue assertion failed");
`define SPQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue assertion failed");
`else
`define SPQ_ASSERT(name, prop)
`define SPQ_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* rtl/core/spq_pkg.sv */
// Shared constants, codes and types of the sorted priority queue unit.
// No dependencies; every other file but the assertion macro header imports this package.
`timescale 1ns / 1ps
package spq_pkg;
    localparam int OP_W            = 2;
    localparam int DATA_W          = 32;
    localparam int PRI_W           = 8;
    localparam int STATUS_W        = 2;
    localparam int OCC_W           = 5;
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [PRI_W-1:0]    t_pri;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_PUSH  = 2'd0;
    localparam t_op OP_POP   = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
        t_pri pri;
    } t_cell_ctl;
endpackage

/* rtl/core/spq_in_if.sv */
// Input channel of the sorted priority queue unit: one operation per transaction.
// Depends on spq_pkg.
`timescale 1ns / 1ps
interface spq_in_if import spq_pkg::*; ;
    logic               valid;
    logic               ready;
    t_op                operation;
    logic signed [DATA_W-1:0] value_in;
    t_pri               priority_in;

    modport source (output valid, output operation, output value_in, output priority_in,
                    input ready);
    modport sink   (input valid, input operation, input value_in, input priority_in,
                    output ready);
endinterface

/* rtl/core/spq_out_if.sv */
// Result channel of the sorted priority queue unit: one result per transaction.
// Depends on spq_pkg.
`timescale 1ns / 1ps
interface spq_out_if import spq_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_out;
    t_status                  status;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output value_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input value_out, input status, input occupancy,
                     output ready);
endinterface

/* rtl/core/spq_cell.sv */
// One storage cell of the queue chain: holds a value and its priority.
// Depends on spq_pkg; takes data from its left or right neighbor.
`timescale 1ns / 1ps
module spq_cell import spq_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_new_val,
    input  logic                   i_occupied,
    input  logic                   i_prev_keep,
    input  logic [VALUE_WIDTH-1:0] i_prev_val,
    input  t_pri                   i_prev_pri,
    input  logic [VALUE_WIDTH-1:0] i_next_val,
    input  t_pri                   i_next_pri,
    output logic                   o_keep,
    output logic [VALUE_WIDTH-1:0] o_val,
    output t_pri                   o_pri
);
    logic [VALUE_WIDTH-1:0] r_val;
    t_pri                   r_pri;

    // A cell keeps its entry on a push when it is occupied and outranks or ties the new one.
    assign o_keep = i_occupied && (r_pri >= i_ctl.pri);
    assign o_val  = r_val;
    assign o_pri  = r_pri;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !o_keep) begin
            if (i_prev_keep) begin
                r_val <= i_new_val;
                r_pri <= i_ctl.pri;
            end else begin
                r_val <= i_prev_val;
                r_pri <= i_prev_pri;
            end
        end else if (i_ctl.pop) begin
            r_val <= i_next_val;
            r_pri <= i_next_pri;
        end
    end
endmodule

/* rtl/core/spq_ctrl.sv */
// Control of the sorted priority queue: handshake, entry count and result register.
// Depends on spq_pkg; drives the shared cell controls of the chain.
`timescale 1ns / 1ps
module spq_ctrl import spq_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int CNT_W       = $clog2(DEPTH_DEF + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_op                      i_op,
    input  logic signed [DATA_W-1:0] i_value,
    input  t_pri                     i_pri,
    input  logic [VALUE_WIDTH-1:0]   i_head_val,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_value,
    output t_status                  o_status,
    output logic [OCC_W-1:0]         o_occ,
    output t_cell_ctl                o_ctl,
    output logic [VALUE_WIDTH-1:0]   o_new_val,
    output logic [CNT_W-1:0]         o_count
);
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_value;
    t_status                  r_status;
    logic [OCC_W-1:0]         r_occ;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_push_ok;
    logic                     w_pop_ok;
    logic [DATA_W-1:0]        w_head32;
    t_status                  w_status;
    logic [63:0]              w_head_ext;
    logic [63:0]              w_in_ext;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_head_ext = 64'($signed(i_head_val));
    assign w_head32   = w_head_ext[DATA_W-1:0];
    assign w_in_ext   = 64'(i_value);
    assign o_new_val  = w_in_ext[VALUE_WIDTH-1:0];

    always_comb begin
        w_push_ok = 1'b0;
        w_pop_ok  = 1'b0;
        w_status  = STATUS_OK;
        n_count   = r_count;
        case (i_op)
            OP_PUSH: begin
                if (w_full) begin
                    w_status = STATUS_FULL;
                end else begin
                    w_push_ok = w_accept;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    w_status = STATUS_EMPTY;
                end else begin
                    w_pop_ok = w_accept;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign o_ctl.push = w_push_ok;
    assign o_ctl.pop  = w_pop_ok;
    assign o_ctl.pri  = i_pri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value  <= w_pop_ok ? $signed(w_head32) : '0;
            r_status <= w_status;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_status;
    assign o_occ    = r_occ;
    assign o_count  = r_count;
endmodule

/* rtl/core/sorted_priority_queue_unit.sv */
// Sorted priority queue unit: a bounded queue kept in descending priority order.
// Each input transaction carries a push, a pop of the head or a clear of all entries.
// Every input transaction yields exactly one result transaction with the popped
// value (zero unless a pop succeeded), a status and the occupancy afterward.
// Equal priorities leave in arrival order; a push onto a full queue is dropped
// and reported with the full status, a pop on an empty queue with the empty status.
// The entries sit in a row of DEPTH cells; on each operation every cell compares
// its priority with the new one and shifts in parallel, so any operation finishes
// in the cycle it is accepted, whatever the occupancy.
// The result is registered: it appears in the cycle after acceptance, and one
// transaction per cycle is sustained while the receiver takes results.
// When the receiver stalls, the result is held and input ready drops until it
// is taken. Reset empties the queue and clears the pending result; the cell
// contents are not cleared since only occupied cells are ever read.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_ctrl and spq_cell.
`timescale 1ns / 1ps
`include "sorted_priority_queue_unit_defines.svh"
module sorted_priority_queue_unit import spq_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cell_ctl              w_ctl;
    logic [VALUE_WIDTH-1:0] w_new_val;
    logic [CNT_W-1:0]       w_count;
    logic [VALUE_WIDTH-1:0] w_val  [DEPTH];
    t_pri                   w_pri  [DEPTH];
    logic                   w_keep [DEPTH];
    logic                   w_full_push;

    spq_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_op       (i_in.operation),
        .i_value    (i_in.value_in),
        .i_pri      (i_in.priority_in),
        .i_head_val (w_val[0]),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_value    (o_out.value_out),
        .o_status   (o_out.status),
        .o_occ      (o_out.occupancy),
        .o_ctl      (w_ctl),
        .o_new_val  (w_new_val),
        .o_count    (w_count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;

        spq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new_val   (w_new_val),
            .i_occupied  (CNT_W'(g) < w_count),
            .i_prev_keep ((g == 0) ? 1'b1 : w_keep[PREV]),
            .i_prev_val  (w_val[PREV]),
            .i_prev_pri  (w_pri[PREV]),
            .i_next_val  (w_val[NEXT]),
            .i_next_pri  (w_pri[NEXT]),
            .o_keep      (w_keep[g]),
            .o_val       (w_val[g]),
            .o_pri       (w_pri[g])
        );
    end

    assign w_full_push = i_in.valid && i_in.ready && (i_in.operation == OP_PUSH)
                         && (w_count == CNT_W'(DEPTH));

    `SPQ_ASSERT(a_count_bounded, w_count <= CNT_W'(DEPTH))
    `SPQ_ASSERT(a_head_sorted, (w_count < CNT_W'(2)) || (w_pri[0] >= w_pri[1]))
    `SPQ_ASSERT_NEXT(a_full_push_dropped, w_full_push, $stable(w_count))
    `SPQ_ASSERT_NEXT(a_result_follows, i_in.valid && i_in.ready, o_out.valid)
endmodule

/* test/sorted_priority_queue_unit_test.sv */
// Self-checking testbench for the sorted priority queue unit: pushes, pops, clears and no-ops
// are checked against a behavioral model of the sorted store under random idle and stall.
// Depends on spq_pkg, spq_in_if, spq_out_if and sorted_priority_queue_unit.
`timescale 1ns / 1ps
module sorted_priority_queue_unit_test;
    import spq_pkg::*;

    localparam t_op OP_NOP = 2'd3;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
        t_pri                     pri;
    } t_queue_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_queue_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_queue_op     pending_ops[$];
    t_queue_result expected_results[$];

    logic signed [DATA_W-1:0] held_value[DEPTH_DEF];
    t_pri                     held_pri[DEPTH_DEF];
    int                       held_count = 0;

    int ops_sent = 0;
    int mismatches = 0;
    int send_idle_pct;
    int take_stall_pct;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always_comb begin
        case ((ops_sent / 100) % 4)
            0: begin
                send_idle_pct = 0;
                take_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 72;
                take_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                take_stall_pct = 72;
            end
            default: begin
                send_idle_pct = 9;
                take_stall_pct = 9;
            end
        endcase
    end

    function automatic t_queue_result apply_queue_op(t_queue_op cmd);
        t_queue_result res;
        int slot;
        res.value = '0;
        res.status = STATUS_OK;
        case (cmd.op)
            OP_PUSH: begin
                if (held_count >= DEPTH_DEF) begin
                    res.status = STATUS_FULL;
                end else begin
                    slot = 0;
                    while (slot < held_count && held_pri[slot] >= cmd.pri) slot++;
                    for (int k = held_count; k > slot; k--) begin
                        held_value[k] = held_value[k-1];
                        held_pri[k] = held_pri[k-1];
                    end
                    held_value[slot] = cmd.value;
                    held_pri[slot] = cmd.pri;
                    held_count++;
                end
            end
            OP_POP: begin
                if (held_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.value = held_value[0];
                    for (int k = 0; k + 1 < held_count; k++) begin
                        held_value[k] = held_value[k+1];
                        held_pri[k] = held_pri[k+1];
                    end
                    held_count--;
                end
            end
            OP_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(held_count);
        return res;
    endfunction

    task automatic add_op(t_op op, logic signed [DATA_W-1:0] value, t_pri pri);
        t_queue_op cmd;
        cmd.op = op;
        cmd.value = value;
        cmd.pri = pri;
        pending_ops.push_back(cmd);
    endtask

    always @(posedge i_clk) begin : drive_ops
        t_queue_op cmd;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.operation <= OP_PUSH;
            in_ch.value_in <= '0;
            in_ch.priority_in <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                cmd.op = in_ch.operation;
                cmd.value = in_ch.value_in;
                cmd.pri = in_ch.priority_in;
                expected_results.push_back(apply_queue_op(cmd));
                ops_sent <= ops_sent + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd = pending_ops.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.operation <= cmd.op;
                    in_ch.value_in <= cmd.value;
                    in_ch.priority_in <= cmd.pri;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_queue_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no operation outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.value_out !== want.value) begin
                        $error("value_out: expected %0d, got %0d", want.value, out_ch.value_out);
                        mismatches++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        mismatches++;
                    end
                    if (out_ch.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy,
                               out_ch.occupancy);
                        mismatches++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    initial begin
        int burst_len;
        int push_pct;
        int pri_span;
        int roll;
        i_rst_n = 1'b0;

        add_op(OP_POP, 32'sd0, 8'd0);
        add_op(OP_NOP, -32'sd1, 8'hFF);
        add_op(OP_PUSH, 32'sh7FFF_FFFF, 8'd0);
        add_op(OP_PUSH, 32'sh8000_0000, 8'd255);
        add_op(OP_PUSH, -32'sd1, 8'd255);
        add_op(OP_PUSH, 32'sd0, 8'd0);
        add_op(OP_PUSH, 32'sd1, 8'd128);
        for (int i = 0; i < 11; i++) add_op(OP_PUSH, 32'sh5A5A_0000 + i, t_pri'((i * 37) % 256));
        add_op(OP_PUSH, 32'sh1234_5678, 8'd255);
        add_op(OP_NOP, 32'sd0, 8'd0);
        add_op(OP_POP, 32'sd0, 8'd0);
        add_op(OP_POP, 32'sd0, 8'd0);
        add_op(OP_CLEAR, 32'sd0, 8'd0);
        add_op(OP_POP, 32'sd0, 8'd0);
        add_op(OP_PUSH, 32'sd42, 8'd7);

        while (pending_ops.size() < 825) begin
            burst_len = $urandom_range(24, 4);
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 20;
                default: push_pct = 52;
            endcase
            pri_span = ($urandom_range(1) == 0) ? 3 : 255;
            for (int i = 0; i < burst_len; i++) begin
                roll = $urandom_range(99);
                if (roll < 2)
                    add_op(OP_CLEAR, $urandom, t_pri'($urandom));
                else if (roll < 4)
                    add_op(OP_NOP, $urandom, t_pri'($urandom));
                else if ($urandom_range(99) < push_pct)
                    add_op(OP_PUSH, $urandom, t_pri'($urandom_range(pri_span)));
                else
                    add_op(OP_POP, $urandom, t_pri'($urandom));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sorted_priority_queue_unit_test OK");
        end else begin
            $display("sorted_priority_queue_unit_test NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("sorted_priority_queue_unit_test NOT OK");
        $finish;
    end
endmodule
